// ----- rtl/core/ccrc_pkg.sv -----
package ccrc_pkg;

   localparam int CrcW  = 32;
   localparam int DataW = 8;
   localparam int ModeW = 2;
   localparam int IdxW  = 3;
   localparam int ShW   = 5;

   localparam logic [ModeW-1:0] MODE_CRC8  = 2'd0;
   localparam logic [ModeW-1:0] MODE_CRC16 = 2'd1;
   localparam logic [ModeW-1:0] MODE_CRC32 = 2'd2;

   localparam logic [IdxW-1:0] REG_WIDTH_MODE     = 3'd0;
   localparam logic [IdxW-1:0] REG_POLYNOMIAL     = 3'd1;
   localparam logic [IdxW-1:0] REG_INITIAL_VALUE  = 3'd2;
   localparam logic [IdxW-1:0] REG_REFLECT_INPUT  = 3'd3;
   localparam logic [IdxW-1:0] REG_REFLECT_OUTPUT = 3'd4;
   localparam logic [IdxW-1:0] REG_FINAL_XOR      = 3'd5;

   typedef struct packed {
      logic [ModeW-1:0] width_mode;
      logic [CrcW-1:0]  polynomial;
      logic [CrcW-1:0]  initial_value;
      logic             reflect_input;
      logic             reflect_output;
      logic [CrcW-1:0]  final_xor;
   } csr_type;

   localparam csr_type CSR_RESET = '{
      width_mode:     MODE_CRC32,
      polynomial:     32'h814141AB,
      initial_value:  32'h0,
      reflect_input:  1'b0,
      reflect_output: 1'b0,
      final_xor:      32'h0
   };

   // left shift that puts the CRC msb at bit 31; unused code acts as 32 bits
   function automatic logic [ShW-1:0] align_shift(input logic [ModeW-1:0] mode);
      logic [ShW-1:0] sh;
      case (mode)
         MODE_CRC8:  sh = 5'd24;
         MODE_CRC16: sh = 5'd16;
         default:    sh = 5'd0;
      endcase
      return sh;
   endfunction

   function automatic logic [DataW-1:0] reverse8(input logic [DataW-1:0] v);
      logic [DataW-1:0] r;
      for (int i = 0; i < DataW; i++) begin
         r[i] = v[DataW-1-i];
      end
      return r;
   endfunction

   function automatic logic [CrcW-1:0] reverse32(input logic [CrcW-1:0] v);
      logic [CrcW-1:0] r;
      for (int i = 0; i < CrcW; i++) begin
         r[i] = v[CrcW-1-i];
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/ccrc_csr.sv -----
module ccrc_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [ccrc_pkg::IdxW-1:0]  csr_index,
   input  logic [ccrc_pkg::CrcW-1:0]  csr_write_data,
   output ccrc_pkg::csr_type          cfg
);
   import ccrc_pkg::*;

   csr_type cfg_ff;
   csr_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_WIDTH_MODE:     cfg_in.width_mode     = csr_write_data[ModeW-1:0];
            REG_POLYNOMIAL:     cfg_in.polynomial     = csr_write_data;
            REG_INITIAL_VALUE:  cfg_in.initial_value  = csr_write_data;
            REG_REFLECT_INPUT:  cfg_in.reflect_input  = csr_write_data[0];
            REG_REFLECT_OUTPUT: cfg_in.reflect_output = csr_write_data[0];
            REG_FINAL_XOR:      cfg_in.final_xor      = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CSR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/ccrc_fold.sv -----
module ccrc_fold (
   input  ccrc_pkg::csr_type          cfg,
   input  logic                       in_message,
   input  logic [ccrc_pkg::CrcW-1:0]  crc_state,
   input  logic [ccrc_pkg::DataW-1:0] data_byte,
   output logic [ccrc_pkg::CrcW-1:0]  next_crc,
   output logic [ccrc_pkg::CrcW-1:0]  final_crc
);
   import ccrc_pkg::*;

   logic [ShW-1:0]   shift;
   logic [CrcW-1:0]  mask;
   logic [CrcW-1:0]  start;
   logic [CrcW-1:0]  poly_al;
   logic [DataW-1:0] byte_in;
   logic [CrcW-1:0]  acc;
   logic [CrcW-1:0]  ordered;

   // work msb-aligned at bit 31 so one datapath serves all widths
   always_comb begin
      shift   = align_shift(cfg.width_mode);
      mask    = 32'hFFFF_FFFF >> shift;
      start   = in_message ? crc_state : cfg.initial_value;
      poly_al = cfg.polynomial << shift;
      byte_in = cfg.reflect_input ? reverse8(data_byte) : data_byte;
      acc     = (start << shift) ^ {byte_in, {(CrcW-DataW){1'b0}}};
      for (int i = 0; i < DataW; i++) begin
         acc = acc[CrcW-1] ? ((acc << 1) ^ poly_al) : (acc << 1);
      end
      next_crc  = acc >> shift;
      ordered   = cfg.reflect_output ? reverse32(acc) : next_crc;
      final_crc = (ordered ^ cfg.final_xor) & mask;
   end

endmodule

// ----- rtl/core/configurable_crc_engine_top.sv -----
// CRC engine for 8, 16 or 32 bit CRCs. One message byte per transaction on
// the req_ channel; the byte with req_last_byte set produces one rsp_
// transaction carrying the final CRC, zero above the selected width, and the
// engine rearms so the next byte starts a new message from initial_value.
// Throughput is one byte per clock while req_ is not stalled: the eight-bit
// fold of a byte into the running CRC register is combinational and feeds
// that register directly. A byte is captured in the input register when it
// is accepted and folded from there; a last byte's final CRC is registered
// in the result register as it folds. A last byte waits in the input
// register while a stalled result is held, and req_ stalls for those
// cycles. Program the csr_ registers only while the engine is idle.
module configurable_crc_engine_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_crc_value,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   import ccrc_pkg::*;

   csr_type cfg;

   logic             in_valid_ff,  in_valid_in;
   logic [DataW-1:0] in_data_ff,   in_data_in;
   logic             in_last_ff,   in_last_in;
   logic [CrcW-1:0]  crc_ff,       crc_in;
   logic             msg_ff,       msg_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CrcW-1:0]  rsp_crc_ff,   rsp_crc_in;

   logic            advance;
   logic            req_take;
   logic [CrcW-1:0] next_crc;
   logic [CrcW-1:0] final_crc;

   ccrc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   ccrc_fold u_fold (
      .cfg        (cfg),
      .in_message (msg_ff),
      .crc_state  (crc_ff),
      .data_byte  (in_data_ff),
      .next_crc   (next_crc),
      .final_crc  (final_crc)
   );

   // a last byte may fold only when the result register is free or draining
   assign advance   = in_valid_ff && (!in_last_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_data_in   = req_take ? req_data_byte : in_data_ff;
      in_last_in   = req_take ? req_last_byte : in_last_ff;
      crc_in       = advance ? next_crc : crc_ff;
      msg_in       = advance ? !in_last_ff : msg_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_crc_in   = rsp_crc_ff;
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_crc_in   = final_crc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         msg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         crc_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         msg_ff       <= msg_in;
         rsp_valid_ff <= rsp_valid_in;
         crc_ff       <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      in_last_ff <= in_last_in;
      rsp_crc_ff <= rsp_crc_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_crc_value = rsp_crc_ff;

`ifndef SYNTH
   a_last_makes_rsp: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> rsp_valid_ff)
      else $error("last byte folded without a result");

   a_last_rearms: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> !msg_ff)
      else $error("message not rearmed after last byte");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !(advance && in_last_ff))
      else $error("held result overwritten");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && in_last_ff && rsp_valid_ff))
      else $error("input stalled without cause");
`endif

endmodule
